// ===== sv/grr_pkg.sv =====
`default_nettype none

package grr_pkg;

  // Defaults for the top-level parameters
  localparam int GLYPH_COUNT_DEF = 96;
  localparam int CELL_HEIGHT_DEF = 16;
  localparam int MAX_DIM_DEF     = 4096;

  // Glyph cells are always one byte wide
  localparam int CELL_WIDTH = 8;

  // Field widths
  localparam int DIM_W    = 13;
  localparam int POS_W    = 12;
  localparam int COLOR_W  = 32;
  localparam int OFFSET_W = 24;
  localparam int CFG_IDX_W = 3;

  // Character code mapping
  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd127;
  localparam logic [7:0] FALLBACK_CODE = 8'd63;  // question mark

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BGR_ORDER    = 3'd4;

  typedef struct packed {
    logic             enabled;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [DIM_W-1:0] line_stride;
    logic             bgr_order;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } seq_state_t;

  // Swap red and blue bytes in BGR mode; the top byte drops there
  function automatic logic [COLOR_W-1:0] to_raw(input logic bgr,
                                                input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    if (bgr) begin
      r = {8'h00, c[7:0], c[15:8], c[23:16]};
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/grr_cfg_regs.sv =====
`default_nettype none

module grr_cfg_regs #(
  parameter int MAX_DIM = grr_pkg::MAX_DIM_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_write_en,
  input  wire  [grr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [grr_pkg::DIM_W-1:0]       cfg_data,
  output grr_pkg::cfg_t                   cfg
);
  import grr_pkg::*;

  localparam int FW_RST = (1280 > MAX_DIM) ? MAX_DIM : 1280;
  localparam int FH_RST = (720 > MAX_DIM) ? MAX_DIM : 720;

  logic [DIM_W-1:0] dim_sat;

  // Clamp dimension writes to the largest supported frame
  always_comb begin
    if (32'(cfg_data) > MAX_DIM) begin
      dim_sat = DIM_W'(MAX_DIM);
    end else begin
      dim_sat = cfg_data;
    end
  end

  // Register file, writes to unused indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled      <= 1'b0;
      cfg.frame_width  <= DIM_W'(FW_RST);
      cfg.frame_height <= DIM_W'(FH_RST);
      cfg.line_stride  <= DIM_W'(FW_RST);
      cfg.bgr_order    <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_ENABLED:      cfg.enabled      <= cfg_data[0];
        CFG_FRAME_WIDTH:  cfg.frame_width  <= dim_sat;
        CFG_FRAME_HEIGHT: cfg.frame_height <= dim_sat;
        CFG_LINE_STRIDE:  cfg.line_stride  <= dim_sat;
        CFG_BGR_ORDER:    cfg.bgr_order    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/grr_font_mem.sv =====
`default_nettype none

module grr_font_mem #(
  parameter int DEPTH = 1536,
  parameter int AW    = 11
) (
  input  wire           clk,
  input  wire           we,
  input  wire  [AW-1:0] waddr,
  input  wire  [7:0]    wdata,
  input  wire           re,
  input  wire  [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // One write and one registered read per cycle; rdata holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/grr_draw_seq.sv =====
`default_nettype none

module grr_draw_seq #(
  parameter int GLYPH_COUNT = grr_pkg::GLYPH_COUNT_DEF,
  parameter int CELL_HEIGHT = grr_pkg::CELL_HEIGHT_DEF,
  parameter int AW          = 11
) (
  input  wire                               clk,
  input  wire                               rst,
  input  grr_pkg::cfg_t                     cfg,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               kind,
  input  wire  [6:0]                        glyph_index,
  input  wire  [3:0]                        glyph_row,
  input  wire  [7:0]                        row_bits,
  input  wire  [grr_pkg::POS_W-1:0]         pos_x,
  input  wire  [grr_pkg::POS_W-1:0]         pos_y,
  input  wire  [7:0]                        char_code,
  input  wire  [grr_pkg::COLOR_W-1:0]       fore_color,
  input  wire  [grr_pkg::COLOR_W-1:0]       back_color,
  // font store port
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [7:0]                        mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  wire  [7:0]                        mem_rdata,
  // output channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [grr_pkg::OFFSET_W-1:0]      word_offset,
  output logic [7:0][grr_pkg::COLOR_W-1:0]  pix,
  output logic                              last_row
);
  import grr_pkg::*;

  localparam int RW = (CELL_HEIGHT > 1) ? $clog2(CELL_HEIGHT) : 1;

  seq_state_t state, state_next;

  logic                accept;
  logic                draw_ok;
  logic                issue;
  logic                row_is_last;
  logic [7:0]          glyph_sel;

  // per-character working registers
  logic [POS_W-1:0]    px;
  logic [OFFSET_W-1:0] prod;
  logic [OFFSET_W-1:0] offset;
  logic [AW-1:0]       base;
  logic [RW-1:0]       row;
  logic [COLOR_W-1:0]  fg;
  logic [COLOR_W-1:0]  bg;

  // output sidecar registers, aligned with mem_rdata
  logic [COLOR_W-1:0]  out_fg;
  logic [COLOR_W-1:0]  out_bg;

  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && (state == ST_IDLE);
  assign issue       = (state == ST_RUN) && (!out_valid || !out_stall);
  assign row_is_last = (row == RW'(CELL_HEIGHT - 1));

  // Reject when disabled or when the cell crosses the frame edge
  assign draw_ok = (kind == KIND_DRAW) && cfg.enabled &&
                   ((14'(pos_x) + 14'(CELL_WIDTH)) <= 14'(cfg.frame_width)) &&
                   ((14'(pos_y) + 14'(CELL_HEIGHT)) <= 14'(cfg.frame_height));

  // Map the character code to a glyph, falling back to the question mark, then to glyph 0
  always_comb begin
    if (char_code >= FIRST_CODE && char_code <= LAST_CODE) begin
      glyph_sel = char_code - FIRST_CODE;
    end else begin
      glyph_sel = FALLBACK_CODE - FIRST_CODE;
    end
    if (32'(glyph_sel) >= GLYPH_COUNT) begin
      glyph_sel = FALLBACK_CODE - FIRST_CODE;
    end
    if (32'(glyph_sel) >= GLYPH_COUNT) begin
      glyph_sel = 8'd0;
    end
  end

  // Font loads write straight into the store; out-of-range glyphs and rows drop
  assign mem_we    = accept && (kind == KIND_LOAD) &&
                     (32'(glyph_index) < GLYPH_COUNT) &&
                     (32'(glyph_row) < CELL_HEIGHT);
  assign mem_waddr = AW'(32'(glyph_index) * CELL_HEIGHT + 32'(glyph_row));
  assign mem_wdata = row_bits;

  // Glyph row reads, one per free output slot
  assign mem_re    = issue;
  assign mem_raddr = base + AW'(row);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && draw_ok) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: state_next = ST_RUN;
      ST_RUN: begin
        if (issue && row_is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the character and step through its rows
  always_ff @(posedge clk) begin
    if (accept && draw_ok) begin
      px   <= pos_x;
      prod <= OFFSET_W'(25'(pos_y) * 25'(cfg.line_stride));
      base <= AW'(32'(glyph_sel) * CELL_HEIGHT);
      row  <= '0;
      fg   <= to_raw(cfg.bgr_order, fore_color);
      bg   <= to_raw(cfg.bgr_order, back_color);
    end else if (state == ST_SETUP) begin
      offset <= prod + OFFSET_W'(px);
    end else if (issue) begin
      offset <= offset + OFFSET_W'(cfg.line_stride);
      row    <= row + RW'(1);
    end
  end

  // Output stage: load the sidecar with each row read
  always_ff @(posedge clk) begin
    if (issue) begin
      word_offset <= offset;
      last_row    <= row_is_last;
      out_fg      <= fg;
      out_bg      <= bg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Expand the row bitmap, bit 7 leftmost
  always_comb begin
    for (int c = 0; c < CELL_WIDTH; c++) begin
      pix[c] = mem_rdata[CELL_WIDTH - 1 - c] ? out_fg : out_bg;
    end
  end

endmodule

`default_nettype wire

// ===== sv/glyph_row_renderer_top.sv =====
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  --------------------------------------
// cfg       in         cfg_write_en         cfg_index, cfg_data
// in        in         in_valid / in_stall  kind, glyph_index, glyph_row, row_bits,
//                                           pos_x, pos_y, char_code, colors
// out       out        out_valid/out_stall  word_offset, pix0..pix7, last_row
//
// Loads and rejected draws leave the sequencer idle. A drawn character first
// forms the row base product, then adds the column, then makes one font store
// read per row through the single read port. rst is synchronous and clears the
// sequencer, the output valid and the configuration registers; the font store is
// not cleared. out_stall holds the current row and pauses further reads.
`default_nettype none

module glyph_row_renderer_top #(
  parameter int GLYPH_COUNT = grr_pkg::GLYPH_COUNT_DEF,
  parameter int CELL_HEIGHT = grr_pkg::CELL_HEIGHT_DEF,
  parameter int MAX_DIM     = grr_pkg::MAX_DIM_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_write_en,
  input  wire  [grr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [grr_pkg::DIM_W-1:0]     cfg_data,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           kind,
  input  wire  [6:0]                    glyph_index,
  input  wire  [3:0]                    glyph_row,
  input  wire  [7:0]                    row_bits,
  input  wire  [grr_pkg::POS_W-1:0]     pos_x,
  input  wire  [grr_pkg::POS_W-1:0]     pos_y,
  input  wire  [7:0]                    char_code,
  input  wire  [grr_pkg::COLOR_W-1:0]   fore_color,
  input  wire  [grr_pkg::COLOR_W-1:0]   back_color,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [grr_pkg::OFFSET_W-1:0]  word_offset,
  output logic [grr_pkg::COLOR_W-1:0]   pix0,
  output logic [grr_pkg::COLOR_W-1:0]   pix1,
  output logic [grr_pkg::COLOR_W-1:0]   pix2,
  output logic [grr_pkg::COLOR_W-1:0]   pix3,
  output logic [grr_pkg::COLOR_W-1:0]   pix4,
  output logic [grr_pkg::COLOR_W-1:0]   pix5,
  output logic [grr_pkg::COLOR_W-1:0]   pix6,
  output logic [grr_pkg::COLOR_W-1:0]   pix7,
  output logic                          last_row
);
  import grr_pkg::*;

  localparam int DEPTH = GLYPH_COUNT * CELL_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t                     cfg;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [7:0]               mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [7:0]               mem_rdata;
  logic [7:0][COLOR_W-1:0]  pix;

  grr_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  grr_font_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_font (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  grr_draw_seq #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .CELL_HEIGHT (CELL_HEIGHT),
    .AW          (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .glyph_index (glyph_index),
    .glyph_row   (glyph_row),
    .row_bits    (row_bits),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .char_code   (char_code),
    .fore_color  (fore_color),
    .back_color  (back_color),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .word_offset (word_offset),
    .pix         (pix),
    .last_row    (last_row)
  );

  assign pix0 = pix[0];
  assign pix1 = pix[1];
  assign pix2 = pix[2];
  assign pix3 = pix[3];
  assign pix4 = pix[4];
  assign pix5 = pix[5];
  assign pix6 = pix[6];
  assign pix7 = pix[7];

endmodule

`default_nettype wire

// ===== sv/grr_checker.sv =====
`default_nettype none

module grr_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        kind,
  input wire        out_valid,
  input wire        out_stall,
  input wire [23:0] word_offset,
  input wire        last_row
);
  import grr_pkg::*;

  // Reset empties the output stage
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A font load never blocks the next transaction
  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == KIND_LOAD) |=> !in_stall)
    else $error("input stalled after a font load");

  // Rows of a character still to come keep the input closed
  a_mid_char_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_row) |-> in_stall)
    else $error("input open in the middle of a character");

  // A stalled row holds its offset and last-row flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(word_offset) && $stable(last_row)))
    else $error("stalled output row changed");

endmodule

bind glyph_row_renderer_top grr_checker u_grr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .word_offset (word_offset),
  .last_row    (last_row)
);

`default_nettype wire
